// ===== rtl/sxc_pkg.sv =====
// ----------------------------------------------------------------------------
// sxc_pkg: shared types and constants for the subarray XOR target counter
// Holds the element, frequency and count widths, the transaction payload
// structs and the control structs passed to the frequency table.
// ----------------------------------------------------------------------------
package sxc_pkg;

	localparam int VALUE_BITS  = 8;
	localparam int TABLE_DEPTH = 1 << VALUE_BITS;
	localparam int FREQ_BITS   = 17;
	localparam int COUNT_BITS  = 32;
	localparam int TARGET_BITS = 8;

	localparam logic [FREQ_BITS-1:0]  FREQ_MAX  = {FREQ_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	typedef logic [VALUE_BITS-1:0] addr_t;
	typedef logic [FREQ_BITS-1:0]  freq_t;
	typedef logic [COUNT_BITS-1:0] count_t;

	typedef struct packed {
		logic [7:0] value;
		logic       last_value;
	} item_t;

	typedef struct packed {
		logic [31:0] running_count;
		logic        final_result;
	} result_t;

	typedef struct packed {
		logic  en;
		addr_t want_addr;
		addr_t pref_addr;
	} tbl_rd_t;

	typedef struct packed {
		logic  en;
		logic  clr;
		addr_t addr;
		freq_t data;
	} tbl_wr_t;

endpackage

// ===== rtl/sxc_freq_table.sv =====
// ----------------------------------------------------------------------------
// sxc_freq_table: prefix frequency table
// A memory with two registered read ports and one write port. Per-entry valid
// bits let one clear request return the whole table to its cleared state, and
// a forwarding register covers a read issued in the cycle of a write.
// ----------------------------------------------------------------------------
module sxc_freq_table (
	input  logic             clk,
	input  logic             arst_n,
	input  sxc_pkg::tbl_rd_t rd,
	input  sxc_pkg::tbl_wr_t wr,
	output sxc_pkg::freq_t   want_freq,
	output sxc_pkg::freq_t   pref_freq
);

	sxc_pkg::freq_t mem [sxc_pkg::TABLE_DEPTH];

	sxc_pkg::freq_t rd_want_q;
	sxc_pkg::freq_t rd_pref_q;
	sxc_pkg::addr_t want_addr_q;
	sxc_pkg::addr_t pref_addr_q;

	logic [sxc_pkg::TABLE_DEPTH-1:0] valid_q;
	logic                            fwd_v_q;
	sxc_pkg::addr_t                  fwd_addr_q;
	sxc_pkg::freq_t                  fwd_data_q;

	logic do_write;

	assign do_write = wr.en && !wr.clr;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_want_q   <= mem[rd.want_addr];
			rd_pref_q   <= mem[rd.pref_addr];
			want_addr_q <= rd.want_addr;
			pref_addr_q <= rd.pref_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fwd_v_q <= 1'b0;
		end else if (wr.en && wr.clr) begin
			valid_q <= '0;
			fwd_v_q <= 1'b0;
		end else if (do_write) begin
			valid_q[wr.addr] <= 1'b1;
			fwd_v_q          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_write) begin
			fwd_addr_q <= wr.addr;
			fwd_data_q <= wr.data;
		end
	end

	// An entry that was never written since the last clear holds one at
	// address zero and zero elsewhere.
	always_comb begin
		if (fwd_v_q && fwd_addr_q == want_addr_q) begin
			want_freq = fwd_data_q;
		end else if (valid_q[want_addr_q]) begin
			want_freq = rd_want_q;
		end else begin
			want_freq = (want_addr_q == '0) ? sxc_pkg::freq_t'(1) : '0;
		end
	end

	always_comb begin
		if (fwd_v_q && fwd_addr_q == pref_addr_q) begin
			pref_freq = fwd_data_q;
		end else if (valid_q[pref_addr_q]) begin
			pref_freq = rd_pref_q;
		end else begin
			pref_freq = (pref_addr_q == '0) ? sxc_pkg::freq_t'(1) : '0;
		end
	end

endmodule

// ===== rtl/subarray_xor_target_counter_core.sv =====
// ----------------------------------------------------------------------------
// subarray_xor_target_counter_core: counts subarrays whose XOR equals a target
// An accepted transaction moves through stage s1 (table read) into the result
// register. Throughput is one transaction per cycle while the result output is
// not stalled; the table read, update and write overlap through write forwarding.
// Reset clears the prefix, the count, the target and the table.
// ----------------------------------------------------------------------------
module subarray_xor_target_counter_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             target_we,
	input  logic [7:0]       target_wdata,
	input  logic             item_valid,
	output logic             item_ready,
	input  sxc_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output sxc_pkg::result_t result
);

	logic [sxc_pkg::TARGET_BITS-1:0] target_q;
	sxc_pkg::addr_t                  prefix_q;
	sxc_pkg::count_t                 count_q;

	logic           valid_s1;
	logic           last_s1;
	sxc_pkg::addr_t prefix_s1;

	logic             result_valid_q;
	sxc_pkg::result_t result_q;

	logic            out_free;
	logic            adv_s1;
	logic            accept;
	sxc_pkg::addr_t  prefix_next;
	sxc_pkg::addr_t  want_addr;
	sxc_pkg::tbl_rd_t rd;
	sxc_pkg::tbl_wr_t wr;
	sxc_pkg::freq_t  want_freq;
	sxc_pkg::freq_t  pref_freq;
	sxc_pkg::freq_t  freq_inc;
	logic [sxc_pkg::COUNT_BITS:0] sum;
	sxc_pkg::count_t new_count;

	assign out_free   = !result_valid_q || result_ready;
	assign adv_s1     = valid_s1 && out_free;
	assign item_ready = !valid_s1 || out_free;
	assign accept     = item_valid && item_ready;

	assign prefix_next = prefix_q ^ item.value[sxc_pkg::VALUE_BITS-1:0];
	assign want_addr   = prefix_next ^ target_q[sxc_pkg::VALUE_BITS-1:0];

	assign rd.en        = accept;
	assign rd.want_addr = want_addr;
	assign rd.pref_addr = prefix_next;

	sxc_freq_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.wr        (wr),
		.want_freq (want_freq),
		.pref_freq (pref_freq)
	);

	assign sum       = {1'b0, count_q} + (sxc_pkg::COUNT_BITS + 1)'(want_freq);
	assign new_count = sum[sxc_pkg::COUNT_BITS] ? sxc_pkg::COUNT_MAX
		: sum[sxc_pkg::COUNT_BITS-1:0];
	assign freq_inc  = (pref_freq == sxc_pkg::FREQ_MAX) ? pref_freq
		: pref_freq + sxc_pkg::freq_t'(1);

	assign wr.en   = adv_s1;
	assign wr.clr  = last_s1;
	assign wr.addr = prefix_s1;
	assign wr.data = freq_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
		end else if (target_we) begin
			target_q <= target_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
		end else if (accept) begin
			prefix_q <= item.last_value ? '0 : prefix_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			last_s1   <= item.last_value;
			prefix_s1 <= prefix_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (adv_s1) begin
			count_q <= last_s1 ? '0 : new_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q.running_count <= new_count;
			result_q.final_result  <= last_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// ===== rtl/sxc_checker.sv =====
// ----------------------------------------------------------------------------
// sxc_checker: port-level checks for the subarray XOR target counter
// Tracks transactions in flight and the last count of the open array, and
// checks the input handshake and the ordering and range of results on the ports.
// ----------------------------------------------------------------------------
module sxc_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_valid,
	input logic             item_ready,
	input logic             result_valid,
	input logic             result_ready,
	input sxc_pkg::result_t result
);

	logic [1:0]      outstanding_q;
	logic            open_q;
	sxc_pkg::count_t last_cnt_q;
	logic            in_acc;
	logic            out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = result_valid && result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
			open_q        <= 1'b0;
			last_cnt_q    <= '0;
		end else begin
			outstanding_q <= outstanding_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc) begin
				open_q     <= !result.final_result;
				last_cnt_q <= result.running_count;
			end
		end
	end

	// A stalled result transaction holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// With the result slot empty, the block always takes input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> item_ready)
		else $error("input blocked with empty result slot");

	// No result appears without an accepted input transaction behind it.
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> outstanding_q != 2'd0)
		else $error("result without input transaction");

	// Within one array the count never decreases.
	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && open_q |-> result.running_count >= last_cnt_q)
		else $error("running count decreased within an array");

	// The first element of an array can close at most one subarray.
	a_first_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !open_q |-> result.running_count <= 32'd1)
		else $error("first count of an array above one");

endmodule

bind subarray_xor_target_counter_core sxc_checker u_sxc_checker (.*);
